// ===== design/qfrm_pkg.sv =====
// Package for the rotation-matrix-to-quaternion pipeline.
// Holds widths, branch codes and the shared stage payload types.
package qfrm_pkg;

   localparam int ElemW   = 16;
   localparam int RadW    = 18;
   localparam int SqArgW  = 30;
   localparam int RootW   = 15;
   localparam int RecipW  = 29;
   localparam int NumW    = 17;
   localparam int SqSteps = 15;
   localparam int DivSteps = 29;
   localparam int DefSqPerStage  = 3;
   localparam int DefDivPerStage = 4;

   typedef enum logic [1:0] {
      BR_TRACE = 2'd0,
      BR_X     = 2'd1,
      BR_Y     = 2'd2,
      BR_Z     = 2'd3
   } branch_type;

   typedef struct packed {
      branch_type                  branch;
      logic signed [NumW-1:0]      num0;
      logic signed [NumW-1:0]      num1;
      logic signed [NumW-1:0]      num2;
   } side_type;

   typedef struct packed {
      logic [SqArgW-1:0] rem;
      logic [RootW-1:0]  root;
   } sq_state_type;

   typedef struct packed {
      logic [RecipW-1:0] rem;
      logic [RecipW-1:0] quo;
      logic [RootW-1:0]  den;
   } div_state_type;

endpackage

// ===== design/qfrm_if.sv =====
// Valid/ready channel interface with a generic payload.
// Depends on nothing.
interface qfrm_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== design/qfrm_front.sv =====
// Front stage: branch choice, radicand and numerators, registered.
// Depends on qfrm_pkg.
module qfrm_front (
   input  logic                                clock,
   input  logic                                advance,
   input  logic signed [qfrm_pkg::ElemW-1:0]   e [9],
   output logic [qfrm_pkg::SqArgW-1:0]         sq_arg_ff,
   output qfrm_pkg::side_type                  side_ff
);
   import qfrm_pkg::*;

   logic signed [RadW-1:0] e00, e11, e22, trace, rad;
   logic [SqArgW-1:0]      sq_arg_in;
   side_type               side_in;

   always_comb begin
      e00 = RadW'(e[0]);
      e11 = RadW'(e[4]);
      e22 = RadW'(e[8]);
      trace = e00 + e11 + e22;
      if (trace > 0) begin
         side_in.branch = BR_TRACE;
         rad = trace;
         side_in.num0 = NumW'(e[5]) - NumW'(e[7]);
         side_in.num1 = NumW'(e[6]) - NumW'(e[2]);
         side_in.num2 = NumW'(e[1]) - NumW'(e[3]);
      end else if (e00 > e11 && e00 > e22) begin
         side_in.branch = BR_X;
         rad = e00 - e11 - e22;
         side_in.num0 = NumW'(e[5]) - NumW'(e[7]);
         side_in.num1 = NumW'(e[1]) + NumW'(e[3]);
         side_in.num2 = NumW'(e[2]) + NumW'(e[6]);
      end else if (e11 > e22) begin
         side_in.branch = BR_Y;
         rad = e11 - e00 - e22;
         side_in.num0 = NumW'(e[6]) - NumW'(e[2]);
         side_in.num1 = NumW'(e[1]) + NumW'(e[3]);
         side_in.num2 = NumW'(e[5]) + NumW'(e[7]);
      end else begin
         side_in.branch = BR_Z;
         rad = e22 - e00 - e11;
         side_in.num0 = NumW'(e[1]) - NumW'(e[3]);
         side_in.num1 = NumW'(e[2]) + NumW'(e[6]);
         side_in.num2 = NumW'(e[5]) + NumW'(e[7]);
      end
      rad = rad + RadW'(16384);
      if (rad < 0) begin
         sq_arg_in = '0;
      end else begin
         sq_arg_in = {rad[17:0], 12'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_arg_ff <= sq_arg_in;
         side_ff   <= side_in;
      end
   end
endmodule

// ===== design/qfrm_sqrt_stage.sv =====
// One pipeline stage of a restoring integer square root, STEPS bits per stage.
// Depends on qfrm_pkg.
module qfrm_sqrt_stage #(
   parameter int FIRST = 0,
   parameter int STEPS = 3
) (
   input  logic                       clock,
   input  logic                       advance,
   input  qfrm_pkg::sq_state_type     st,
   input  qfrm_pkg::side_type         side,
   output qfrm_pkg::sq_state_type     st_ff,
   output qfrm_pkg::side_type         side_ff
);
   import qfrm_pkg::*;

   sq_state_type st_in;
   logic [SqArgW+1:0] trial;
   logic [SqArgW+1:0] part;

   always_comb begin
      st_in = st;
      for (int k = 0; k < STEPS; k++) begin
         if (FIRST + k < SqSteps) begin
            part  = (SqArgW+2)'(st_in.rem >> (2 * (SqSteps - 1 - FIRST - k)));
            trial = (SqArgW+2)'({st_in.root, 2'b01});
            st_in.root = {st_in.root[RootW-2:0], 1'b0};
            if (part >= trial) begin
               st_in.rem = st_in.rem - SqArgW'(trial << (2 * (SqSteps - 1 - FIRST - k)));
               st_in.root[0] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st_ff   <= st_in;
         side_ff <= side;
      end
   end
endmodule

// ===== design/qfrm_div_stage.sv =====
// One pipeline stage of a restoring divide of 2^28 by the root, STEPS bits per stage.
// Depends on qfrm_pkg.
module qfrm_div_stage #(
   parameter int FIRST = 0,
   parameter int STEPS = 4
) (
   input  logic                       clock,
   input  logic                       advance,
   input  qfrm_pkg::div_state_type    st,
   input  qfrm_pkg::side_type         side,
   output qfrm_pkg::div_state_type    st_ff,
   output qfrm_pkg::side_type         side_ff
);
   import qfrm_pkg::*;

   div_state_type st_in;
   logic [RecipW:0] sh;

   always_comb begin
      st_in = st;
      for (int k = 0; k < STEPS; k++) begin
         if (FIRST + k < DivSteps) begin
            sh = {st_in.rem, (FIRST + k == 0) ? 1'b1 : 1'b0};
            st_in.quo = {st_in.quo[RecipW-2:0], 1'b0};
            if (sh >= (RecipW+1)'(st_in.den)) begin
               sh = sh - (RecipW+1)'(st_in.den);
               st_in.quo[0] = 1'b1;
            end
            st_in.rem = sh[RecipW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st_ff   <= st_in;
         side_ff <= side;
      end
   end
endmodule

// ===== design/qfrm_scale.sv =====
// Scaling stages: numerator times reciprocal, then rounding and saturation.
// Depends on qfrm_pkg.
module qfrm_scale (
   input  logic                         clock,
   input  logic                         advance_mul,
   input  logic                         advance_out,
   input  logic [qfrm_pkg::RecipW-1:0]  recip,
   input  logic [qfrm_pkg::RootW-1:0]   root,
   input  qfrm_pkg::side_type           side,
   output logic [4*16+1:0]              result_ff
);
   import qfrm_pkg::*;

   logic [NumW+RecipW-1:0] prod_ff [3];
   logic [NumW+RecipW-1:0] prod_in [3];
   logic [2:0]             neg_ff, neg_in;
   logic [RootW-1:0]       root_ff;
   branch_type             branch_ff;
   logic [15:0]            comp [3];
   logic [15:0]            rv;
   logic [NumW-1:0]        mag;
   logic [NumW+RecipW-1:0] q;
   logic [4*16+1:0]        result_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         case (i)
            0: mag = side.num0[NumW-1] ? NumW'(-side.num0) : side.num0;
            1: mag = side.num1[NumW-1] ? NumW'(-side.num1) : side.num1;
            default: mag = side.num2[NumW-1] ? NumW'(-side.num2) : side.num2;
         endcase
         prod_in[i] = (NumW+RecipW)'(mag) * (NumW+RecipW)'(recip);
      end
      neg_in = {side.num2[NumW-1], side.num1[NumW-1], side.num0[NumW-1]};
   end

   always_ff @(posedge clock) begin
      if (advance_mul) begin
         prod_ff   <= prod_in;
         neg_ff    <= neg_in;
         root_ff   <= root;
         branch_ff <= side.branch;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         q = (prod_ff[i] + (NumW+RecipW)'(32768)) >> 16;
         if (neg_ff[i]) begin
            comp[i] = (q >= (NumW+RecipW)'(32768)) ? 16'h8000 : 16'(-q[15:0]);
         end else begin
            comp[i] = (q >= (NumW+RecipW)'(32767)) ? 16'h7fff : q[15:0];
         end
      end
      rv = {1'b0, root_ff};
      case (branch_ff)
         BR_TRACE: result_in = {rv, comp[0], comp[1], comp[2], branch_ff};
         BR_X:     result_in = {comp[0], rv, comp[1], comp[2], branch_ff};
         BR_Y:     result_in = {comp[0], comp[1], rv, comp[2], branch_ff};
         default:  result_in = {comp[0], comp[1], comp[2], rv, branch_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance_out) begin
         result_ff <= result_in;
      end
   end
endmodule

// ===== design/quaternion_from_rotation_matrix.sv =====
// Top level: rotation matrix (Q2.14) to unit quaternion (Q2.14), Shepperd's method.
// Depends on qfrm_pkg, qfrm_if, qfrm_front, qfrm_sqrt_stage, qfrm_div_stage, qfrm_scale.
//
//  channel | dir | payload
//  req     | in  | elem_00 .. elem_22, 16 bits signed each
//  rsp     | out | quat_w, quat_x, quat_y, quat_z (16 bits signed), branch_taken (2)
//
// Fully pipelined: one item per cycle while rsp is not stalled. Stages in order:
// front, the square-root stage chain, the reciprocal stage chain, then the
// multiply stage and the rounding and saturation output stage.
// Reset clears the stage valid bits only. A stall on rsp holds every stage
// that has no empty slot downstream; no item is lost or repeated.
module quaternion_from_rotation_matrix #(
   parameter int SQ_PER_STAGE  = qfrm_pkg::DefSqPerStage,
   parameter int DIV_PER_STAGE = qfrm_pkg::DefDivPerStage
) (
   input  logic clock,
   input  logic reset,
   qfrm_if.sink   req,
   qfrm_if.source rsp
);
   import qfrm_pkg::*;

   localparam int NSQ   = (SqSteps + SQ_PER_STAGE - 1) / SQ_PER_STAGE;
   localparam int NDIV  = (DivSteps + DIV_PER_STAGE - 1) / DIV_PER_STAGE;
   localparam int NSTG  = 1 + NSQ + NDIV + 2;

   logic [NSTG-1:0] valid_ff, valid_in, adv;
   logic signed [ElemW-1:0] e [9];

   sq_state_type  sq_st  [NSQ+1];
   side_type      sq_sd  [NSQ+1];
   div_state_type dv_st  [NDIV+1];
   side_type      dv_sd  [NDIV+1];
   logic [RootW-1:0] root_pipe_ff [NDIV];
   logic [RootW-1:0] root_pipe_in [NDIV];
   logic [SqArgW-1:0] sq_arg;
   logic [4*16+1:0]  result;

   always_comb begin
      adv[NSTG-1] = !valid_ff[NSTG-1] || rsp.ready;
      for (int i = NSTG - 2; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
   end

   assign req.ready = adv[0];

   always_comb begin
      valid_in[0] = req.valid;
      for (int i = 1; i < NSTG; i++) begin
         valid_in[i] = valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < NSTG; i++) begin
            if (adv[i]) valid_ff[i] <= valid_in[i];
         end
      end
   end

   assign e[0] = req.data.elem_00;
   assign e[1] = req.data.elem_01;
   assign e[2] = req.data.elem_02;
   assign e[3] = req.data.elem_10;
   assign e[4] = req.data.elem_11;
   assign e[5] = req.data.elem_12;
   assign e[6] = req.data.elem_20;
   assign e[7] = req.data.elem_21;
   assign e[8] = req.data.elem_22;

   qfrm_front u_front (
      .clock(clock), .advance(adv[0]), .e(e), .sq_arg_ff(sq_arg), .side_ff(sq_sd[0])
   );

   assign sq_st[0].rem  = sq_arg;
   assign sq_st[0].root = '0;

   for (genvar g = 0; g < NSQ; g++) begin : g_sq
      qfrm_sqrt_stage #(.FIRST(g * SQ_PER_STAGE), .STEPS(SQ_PER_STAGE)) u_sq (
         .clock(clock), .advance(adv[1+g]), .st(sq_st[g]), .side(sq_sd[g]),
         .st_ff(sq_st[g+1]), .side_ff(sq_sd[g+1])
      );
   end

   assign dv_st[0].rem = '0;
   assign dv_st[0].quo = '0;
   assign dv_st[0].den = (sq_st[NSQ].root == '0) ? RootW'(1) : sq_st[NSQ].root;
   assign dv_sd[0]     = sq_sd[NSQ];

   for (genvar g = 0; g < NDIV; g++) begin : g_div
      qfrm_div_stage #(.FIRST(g * DIV_PER_STAGE), .STEPS(DIV_PER_STAGE)) u_div (
         .clock(clock), .advance(adv[1+NSQ+g]), .st(dv_st[g]), .side(dv_sd[g]),
         .st_ff(dv_st[g+1]), .side_ff(dv_sd[g+1])
      );
      assign root_pipe_in[g] = (g == 0) ? sq_st[NSQ].root : root_pipe_ff[(g == 0) ? 0 : g-1];
      always_ff @(posedge clock) begin
         if (adv[1+NSQ+g]) root_pipe_ff[g] <= root_pipe_in[g];
      end
   end

   qfrm_scale u_scale (
      .clock(clock), .advance_mul(adv[NSTG-2]), .advance_out(adv[NSTG-1]),
      .recip(dv_st[NDIV].quo), .root(root_pipe_ff[NDIV-1]), .side(dv_sd[NDIV]),
      .result_ff(result)
   );

   assign rsp.valid             = valid_ff[NSTG-1];
   assign rsp.data.quat_w       = result[65:50];
   assign rsp.data.quat_x       = result[49:34];
   assign rsp.data.quat_y       = result[33:18];
   assign rsp.data.quat_z       = result[17:2];
   assign rsp.data.branch_taken = branch_type'(result[1:0]);

`ifndef NO_ASSERTIONS
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(result))
      else $error("result changed under stall");
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !valid_ff[NSTG-1] |-> req.ready)
      else $error("input blocked with empty output stage");
   a_root_unit: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && result[1:0] == BR_TRACE |-> !result[65])
      else $error("root negative");
`endif
endmodule
